// ===== sv/obr_pkg.sv =====
// Shared types and constants for the one-bit line and quad rasterizer.
// Depends on nothing; the rasterizer top level imports it.
package obr_pkg;

    localparam int MAX_WIDTH     = 400;
    localparam int MAX_HEIGHT    = 240;
    localparam int ROW_BYTES_MAX = (MAX_WIDTH + 7) / 8;
    localparam int STORE_DEPTH   = MAX_HEIGHT * ROW_BYTES_MAX;
    localparam int ADDR_W        = $clog2(STORE_DEPTH);
    localparam int GUARD_MAX     = 4 * (MAX_WIDTH + MAX_HEIGHT);
    localparam int GUARD_W       = $clog2(GUARD_MAX + 1);

    localparam logic [8:0] VIEW_WIDTH_RESET  = 9'd400;
    localparam logic [7:0] VIEW_HEIGHT_RESET = 8'd240;

    // Quotient bits produced by the crossing divider.
    localparam int DIV_BITS = 27;

    typedef enum logic [1:0] {
        MODE_CLEAR = 2'd0,
        MODE_LINE  = 2'd1,
        MODE_FILL  = 2'd2,
        MODE_READ  = 2'd3
    } mode_t;

    typedef enum logic {
        CFG_VIEW_WIDTH  = 1'b0,
        CFG_VIEW_HEIGHT = 1'b1
    } cfg_index_t;

    typedef enum logic [4:0] {
        ST_BOOT,
        ST_IDLE,
        ST_CLR_INIT,
        ST_CLR,
        ST_RD,
        ST_RD_DONE,
        ST_L_INIT1,
        ST_L_INIT2,
        ST_L_INIT3,
        ST_PLOT,
        ST_WRITE,
        ST_AFTER,
        ST_F_INIT,
        ST_F_ROW,
        ST_F_EDGE,
        ST_F_MUL,
        ST_F_PREP,
        ST_F_DIV,
        ST_F_ACC,
        ST_F_SPAN,
        ST_F_XCHK,
        ST_DONE
    } state_t;

endpackage

// ===== sv/one_bit_line_and_quad_rasterizer_top.sv =====
// Top level of the one-bit line and quad rasterizer: sequencer, shared
// datapath and the byte-wide pixel store. Depends on obr_pkg.
//
// Usage: one command word enters on the input channel (in_valid/in_stall)
// and produces exactly one word on the output channel (out_valid/out_stall).
// read_data carries the stored byte for a read and zero for other modes.
// Registers view_width (index 0) and view_height (index 1) are written on
// the cfg channel, which is always ready; write them only while idle.
// After reset every byte of the store is swept to zero, during which
// in_stall stays high. A command is taken only while the sequencer is idle.
// A pixel is a read-modify-write through the store, a read and then a write,
// done only if the pixel is visible. A line runs its setup states and then
// steps pixel by pixel. A fill walks the rows; per row it tests each edge,
// sends each crossing edge through the shared multiplier and one-bit-per-cycle
// divider, and plots a drawn span pixel by pixel. A clear writes zero to the
// bytes in use; a read fetches one byte of the store.
// The result sits in an output register; a stalled receiver does not stop
// the next command from being accepted, but the block will wait at the end
// of that command until the output register is free.
module one_bit_line_and_quad_rasterizer_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          mode,
    input  logic signed [23:0]  vertex0_x,
    input  logic signed [23:0]  vertex0_y,
    input  logic signed [23:0]  vertex1_x,
    input  logic signed [23:0]  vertex1_y,
    input  logic signed [23:0]  vertex2_x,
    input  logic signed [23:0]  vertex2_y,
    input  logic signed [23:0]  vertex3_x,
    input  logic signed [23:0]  vertex3_y,
    input  logic                ink,
    input  logic [13:0]         read_index,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          read_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [8:0]          cfg_data
);
    import obr_pkg::*;

    function automatic logic signed [16:0] pix24(input logic signed [23:0] v);
        logic signed [24:0] s;
        s = $signed({v[23], v}) + 25'sd128;
        return s[24:8];
    endfunction

    function automatic logic signed [21:0] pix29(input logic signed [28:0] v);
        logic signed [29:0] s;
        s = $signed({v[28], v}) + 30'sd128;
        return s[29:8];
    endfunction

    state_t state_reg, state_next;
    mode_t  mode_reg, mode_next;
    logic   ink_reg, ink_next;
    logic [13:0] ridx_reg, ridx_next;
    logic signed [23:0] vx_reg [4];
    logic signed [23:0] vx_next [4];
    logic signed [23:0] vy_reg [4];
    logic signed [23:0] vy_next [4];
    logic [8:0] width_reg, width_next;
    logic [7:0] height_reg, height_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic [ADDR_W-1:0] clr_n_reg, clr_n_next;
    logic signed [21:0] cur_x_reg, cur_x_next;
    logic signed [16:0] cur_y_reg, cur_y_next;
    logic signed [21:0] x_end_reg, x_end_next;
    logic signed [16:0] y_end_reg, y_end_next;
    logic [17:0] dx_reg, dx_next;
    logic [17:0] dy_reg, dy_next;
    logic sx_neg_reg, sx_neg_next;
    logic sy_neg_reg, sy_neg_next;
    logic signed [19:0] err_reg, err_next;
    logic [GUARD_W-1:0] guard_reg, guard_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic signed [25:0] ediff_reg, ediff_next;
    logic signed [24:0] xdiff_reg, xdiff_next;
    logic [23:0] den_reg, den_next;
    logic dneg_reg, dneg_next;
    logic [1:0] edge_reg, edge_next;
    logic [2:0] hits_reg, hits_next;
    logic signed [50:0] prod_reg, prod_next;
    logic nneg_reg, nneg_next;
    logic [24:0] rem_reg, rem_next;
    logic [DIV_BITS-1:0] quo_reg, quo_next;
    logic [4:0] dcnt_reg, dcnt_next;
    logic signed [28:0] lo_reg, lo_next;
    logic signed [28:0] hi_reg, hi_next;
    logic [7:0] result_reg, result_next;
    logic out_valid_reg, out_valid_next;
    logic [7:0] read_data_reg, read_data_next;

    logic [7:0] store [0:STORE_DEPTH-1];
    logic [7:0] mem_rdata_reg;
    logic mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [7:0] mem_wdata;

    logic [8:0] eff_w;
    logic [7:0] eff_h;
    logic [9:0] w_sum;
    logic [5:0] stride;
    logic [13:0] clear_bytes;
    logic [13:0] plot_addr;
    logic in_view;
    logic [7:0] pix_bit;
    logic signed [21:0] w_s;
    logic signed [24:0] yc;
    logic signed [24:0] ya_s, yb_s;
    logic edge_hit;
    logic signed [25:0] yb_ya;
    logic signed [50:0] num;
    logic signed [52:0] n_full;
    logic [52:0] u_full;
    logic [25:0] div_t;
    logic [24:0] div_d;
    logic signed [27:0] q_s;
    logic signed [28:0] qx;
    logic signed [23:0] ymin_a, ymin_b, ymin_v, ymax_a, ymax_b, ymax_v;
    logic signed [9:0] hm1;
    logic signed [23:0] ylim;
    logic signed [21:0] xa_p, xb_p;
    logic signed [22:0] ddiff;
    logic [18:0] guard_raw;
    logic signed [20:0] e2;
    logic step_x, step_y;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;

    always_comb
    begin
        eff_w = (width_reg > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : width_reg;
        eff_h = (height_reg > 8'(MAX_HEIGHT)) ? 8'(MAX_HEIGHT) : height_reg;
        w_sum = {1'b0, eff_w} + 10'd7;
        stride = w_sum[8:3];
        clear_bytes = 14'(eff_h * stride);
        w_s = $signed({13'b0, eff_w});
        in_view = (cur_x_reg >= 0) && (cur_x_reg < w_s) && (cur_y_reg >= 0)
                  && (cur_y_reg < $signed({9'b0, eff_h}));
        plot_addr = 14'(cur_y_reg[7:0] * stride) + {8'b0, cur_x_reg[8:3]};
        pix_bit = 8'h80 >> cur_x_reg[2:0];
        yc = $signed({cur_y_reg, 8'b0});
        ya_s = 25'(vy_reg[0]);
        yb_s = 25'(vy_reg[1]);
        edge_hit = (ya_s != yb_s) && (((yc >= ya_s) && (yc < yb_s))
                   || ((yc >= yb_s) && (yc < ya_s)));
        yb_ya = 26'(yb_s) - 26'(ya_s);
        num = dneg_reg ? -prod_reg : prod_reg;
        n_full = $signed({num[50], num, 1'b0}) + $signed({29'b0, den_reg});
        u_full = n_full[52] ? ~n_full : n_full;
        div_d = {den_reg, 1'b0};
        div_t = {rem_reg, quo_reg[DIV_BITS-1]};
        q_s = nneg_reg ? ~$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
        qx = 29'(vx_reg[0]) + 29'(q_s);
        ymin_a = (vy_reg[0] < vy_reg[1]) ? vy_reg[0] : vy_reg[1];
        ymin_b = (vy_reg[2] < vy_reg[3]) ? vy_reg[2] : vy_reg[3];
        ymin_v = (ymin_a < ymin_b) ? ymin_a : ymin_b;
        ymax_a = (vy_reg[0] > vy_reg[1]) ? vy_reg[0] : vy_reg[1];
        ymax_b = (vy_reg[2] > vy_reg[3]) ? vy_reg[2] : vy_reg[3];
        ymax_v = (ymax_a > ymax_b) ? ymax_a : ymax_b;
        hm1 = $signed({2'b0, eff_h}) - 10'sd1;
        ylim = 24'($signed({hm1, 8'b0}));
        xa_p = pix29(lo_reg);
        xb_p = pix29(hi_reg);
        ddiff = 23'(x_end_reg) - 23'(cur_x_reg);
        guard_raw = {1'b0, dx_reg} + {1'b0, dy_reg} + 19'd4;
        e2 = $signed({err_reg, 1'b0});
        step_x = e2 > -$signed({3'b0, dy_reg});
        step_y = e2 < $signed({3'b0, dx_reg});
    end

    always_comb
    begin
        state_next = state_reg;
        mode_next = mode_reg;
        ink_next = ink_reg;
        ridx_next = ridx_reg;
        vx_next = vx_reg;
        vy_next = vy_reg;
        width_next = width_reg;
        height_next = height_reg;
        cnt_next = cnt_reg;
        clr_n_next = clr_n_reg;
        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        x_end_next = x_end_reg;
        y_end_next = y_end_reg;
        dx_next = dx_reg;
        dy_next = dy_reg;
        sx_neg_next = sx_neg_reg;
        sy_neg_next = sy_neg_reg;
        err_next = err_reg;
        guard_next = guard_reg;
        addr_next = addr_reg;
        ediff_next = ediff_reg;
        xdiff_next = xdiff_reg;
        den_next = den_reg;
        dneg_next = dneg_reg;
        edge_next = edge_reg;
        hits_next = hits_reg;
        prod_next = prod_reg;
        nneg_next = nneg_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        dcnt_next = dcnt_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        result_next = result_reg;
        out_valid_next = out_valid_reg && out_stall;
        read_data_next = read_data_reg;
        mem_we = 1'b0;
        mem_re = 1'b0;
        mem_waddr = cnt_reg;
        mem_raddr = addr_reg;
        mem_wdata = 8'h00;

        if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_VIEW_WIDTH:  width_next = cfg_data;
                CFG_VIEW_HEIGHT: height_next = cfg_data[7:0];
            endcase
        end

        unique case (state_reg)
            ST_BOOT:
            begin
                mem_we = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ADDR_W'(STORE_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next = mode_t'(mode);
                    ink_next = ink;
                    ridx_next = read_index;
                    vx_next[0] = vertex0_x;
                    vy_next[0] = vertex0_y;
                    vx_next[1] = vertex1_x;
                    vy_next[1] = vertex1_y;
                    vx_next[2] = vertex2_x;
                    vy_next[2] = vertex2_y;
                    vx_next[3] = vertex3_x;
                    vy_next[3] = vertex3_y;
                    result_next = 8'h00;
                    unique case (mode_t'(mode))
                        MODE_CLEAR: state_next = ST_CLR_INIT;
                        MODE_LINE:  state_next = ST_L_INIT1;
                        MODE_FILL:  state_next = ST_F_INIT;
                        MODE_READ:  state_next = ST_RD;
                    endcase
                end
            end
            ST_CLR_INIT:
            begin
                clr_n_next = clear_bytes;
                cnt_next = '0;
                state_next = ST_CLR;
            end
            ST_CLR:
            begin
                if (cnt_reg == clr_n_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    mem_we = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_RD:
            begin
                mem_raddr = ridx_reg;
                mem_re = (ridx_reg < 14'(STORE_DEPTH));
                state_next = ST_RD_DONE;
            end
            ST_RD_DONE:
            begin
                result_next = (ridx_reg < 14'(STORE_DEPTH)) ? mem_rdata_reg : 8'h00;
                state_next = ST_DONE;
            end
            ST_L_INIT1:
            begin
                cur_x_next = 22'(pix24(vx_reg[0]));
                cur_y_next = pix24(vy_reg[0]);
                x_end_next = 22'(pix24(vx_reg[1]));
                y_end_next = pix24(vy_reg[1]);
                state_next = ST_L_INIT2;
            end
            ST_L_INIT2:
            begin
                dx_next = 18'((x_end_reg > cur_x_reg) ? ddiff : -ddiff);
                dy_next = 18'((y_end_reg > cur_y_reg) ? (y_end_reg - cur_y_reg)
                                                      : (cur_y_reg - y_end_reg));
                sx_neg_next = !(cur_x_reg < x_end_reg);
                sy_neg_next = !(cur_y_reg < y_end_reg);
                state_next = ST_L_INIT3;
            end
            ST_L_INIT3:
            begin
                err_next = $signed({2'b0, dx_reg}) - $signed({2'b0, dy_reg});
                guard_next = (guard_raw > 19'(GUARD_MAX)) ? GUARD_W'(GUARD_MAX)
                                                          : GUARD_W'(guard_raw);
                state_next = ST_PLOT;
            end
            ST_PLOT:
            begin
                if (in_view)
                begin
                    mem_re = 1'b1;
                    mem_raddr = plot_addr;
                    addr_next = plot_addr;
                    state_next = ST_WRITE;
                end
                else
                begin
                    state_next = ST_AFTER;
                end
            end
            ST_WRITE:
            begin
                mem_we = 1'b1;
                mem_waddr = addr_reg;
                mem_wdata = ink_reg ? (mem_rdata_reg | pix_bit) : (mem_rdata_reg & ~pix_bit);
                state_next = ST_AFTER;
            end
            ST_AFTER:
            begin
                if (mode_reg == MODE_LINE)
                begin
                    if ((cur_x_reg == x_end_reg && cur_y_reg == y_end_reg)
                        || guard_reg == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        guard_next = guard_reg - 1'b1;
                        err_next = err_reg - (step_x ? $signed({2'b0, dy_reg}) : 20'sd0)
                                   + (step_y ? $signed({2'b0, dx_reg}) : 20'sd0);
                        if (step_x)
                        begin
                            cur_x_next = sx_neg_reg ? cur_x_reg - 22'sd1 : cur_x_reg + 22'sd1;
                        end
                        if (step_y)
                        begin
                            cur_y_next = sy_neg_reg ? cur_y_reg - 17'sd1 : cur_y_reg + 17'sd1;
                        end
                        state_next = ST_PLOT;
                    end
                end
                else
                begin
                    cur_x_next = cur_x_reg + 22'sd1;
                    state_next = ST_F_XCHK;
                end
            end
            ST_F_INIT:
            begin
                cur_y_next = pix24((ymin_v < 0) ? 24'sd0 : ymin_v);
                y_end_next = pix24((ymax_v > ylim) ? ylim : ymax_v);
                state_next = ST_F_ROW;
            end
            ST_F_ROW:
            begin
                if (cur_y_reg > y_end_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    edge_next = '0;
                    hits_next = '0;
                    state_next = ST_F_EDGE;
                end
            end
            ST_F_EDGE:
            begin
                if (edge_hit)
                begin
                    ediff_next = 26'(yc) - 26'(ya_s);
                    xdiff_next = 25'(vx_reg[1]) - 25'(vx_reg[0]);
                    den_next = 24'(yb_ya[25] ? -yb_ya : yb_ya);
                    dneg_next = yb_ya[25];
                    state_next = ST_F_MUL;
                end
                else
                begin
                    // The vertex ring rotates once per edge, so the current edge
                    // always runs from slot 0 to slot 1.
                    for (int k = 0; k < 4; k++)
                    begin
                        vx_next[k] = vx_reg[(k + 1) % 4];
                        vy_next[k] = vy_reg[(k + 1) % 4];
                    end
                    edge_next = edge_reg + 1'b1;
                    if (edge_reg == 2'd3)
                    begin
                        state_next = ST_F_SPAN;
                    end
                end
            end
            ST_F_MUL:
            begin
                prod_next = 51'(ediff_reg * xdiff_reg);
                state_next = ST_F_PREP;
            end
            ST_F_PREP:
            begin
                // A negative numerator is divided as its complement, which
                // turns truncation into the floor the rounding needs.
                nneg_next = n_full[52];
                rem_next = u_full[51:DIV_BITS];
                quo_next = u_full[DIV_BITS-1:0];
                dcnt_next = '0;
                state_next = ST_F_DIV;
            end
            ST_F_DIV:
            begin
                if (div_t >= {1'b0, div_d})
                begin
                    rem_next = 25'(div_t - {1'b0, div_d});
                    quo_next = {quo_reg[DIV_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next = div_t[24:0];
                    quo_next = {quo_reg[DIV_BITS-2:0], 1'b0};
                end
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == 5'(DIV_BITS - 1))
                begin
                    state_next = ST_F_ACC;
                end
            end
            ST_F_ACC:
            begin
                if (hits_reg == '0 || qx < lo_reg)
                begin
                    lo_next = qx;
                end
                if (hits_reg == '0 || qx > hi_reg)
                begin
                    hi_next = qx;
                end
                hits_next = hits_reg + 1'b1;
                for (int k = 0; k < 4; k++)
                begin
                    vx_next[k] = vx_reg[(k + 1) % 4];
                    vy_next[k] = vy_reg[(k + 1) % 4];
                end
                edge_next = edge_reg + 1'b1;
                state_next = (edge_reg == 2'd3) ? ST_F_SPAN : ST_F_EDGE;
            end
            ST_F_SPAN:
            begin
                if (hits_reg < 3'd2)
                begin
                    cur_y_next = cur_y_reg + 17'sd1;
                    state_next = ST_F_ROW;
                end
                else
                begin
                    cur_x_next = (xa_p < 0) ? 22'sd0 : xa_p;
                    x_end_next = (xb_p > w_s - 22'sd1) ? w_s - 22'sd1 : xb_p;
                    state_next = ST_F_XCHK;
                end
            end
            ST_F_XCHK:
            begin
                if (cur_x_reg > x_end_reg)
                begin
                    cur_y_next = cur_y_reg + 17'sd1;
                    state_next = ST_F_ROW;
                end
                else
                begin
                    state_next = ST_PLOT;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    read_data_next = result_reg;
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_BOOT;
            cnt_reg <= '0;
            width_reg <= VIEW_WIDTH_RESET;
            height_reg <= VIEW_HEIGHT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            width_reg <= width_next;
            height_reg <= height_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        ink_reg <= ink_next;
        ridx_reg <= ridx_next;
        vx_reg <= vx_next;
        vy_reg <= vy_next;
        clr_n_reg <= clr_n_next;
        cur_x_reg <= cur_x_next;
        cur_y_reg <= cur_y_next;
        x_end_reg <= x_end_next;
        y_end_reg <= y_end_next;
        dx_reg <= dx_next;
        dy_reg <= dy_next;
        sx_neg_reg <= sx_neg_next;
        sy_neg_reg <= sy_neg_next;
        err_reg <= err_next;
        guard_reg <= guard_next;
        addr_reg <= addr_next;
        ediff_reg <= ediff_next;
        xdiff_reg <= xdiff_next;
        den_reg <= den_next;
        dneg_reg <= dneg_next;
        edge_reg <= edge_next;
        hits_reg <= hits_next;
        prod_reg <= prod_next;
        nneg_reg <= nneg_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dcnt_reg <= dcnt_next;
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        result_reg <= result_next;
        read_data_reg <= read_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= store[mem_raddr];
        end
    end

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result word raised outside the done state");

    a_write_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (mem_waddr < ADDR_W'(STORE_DEPTH)))
        else $error("store write beyond its depth");

    a_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE) |-> $past(state_reg == ST_PLOT))
        else $error("pixel write without a preceding read");

    a_span_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PLOT && mode_reg == MODE_FILL) |-> (cur_x_reg >= 0))
        else $error("fill span starts left of the view");

endmodule

// ===== test/tb.sv =====
// Self-checking bench for the one-bit line and quad rasterizer: a queue-fed
// driver, a result monitor and a bit-exact frame store predictor.
// Depends on obr_pkg and one_bit_line_and_quad_rasterizer_top.
module tb;
    import obr_pkg::*;

    localparam int WATCHDOG_LIMIT = 400000;

    typedef struct {
        mode_t             mode;
        logic signed [23:0] vx [4];
        logic signed [23:0] vy [4];
        logic              ink;
        logic [13:0]       ridx;
    } cmd_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] mode = '0;
    logic signed [23:0] vertex0_x = '0, vertex0_y = '0, vertex1_x = '0, vertex1_y = '0;
    logic signed [23:0] vertex2_x = '0, vertex2_y = '0, vertex3_x = '0, vertex3_y = '0;
    logic ink = 1'b0;
    logic [13:0] read_index = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [7:0] read_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_index = 1'b0;
    logic [8:0] cfg_data = '0;

    cmd_t pending_cmds[$];
    cmd_t cur_cmd;
    logic [7:0] expected_bytes[$];
    logic [7:0] frame [STORE_DEPTH];
    int unsigned view_w = 400;
    int unsigned view_h = 240;
    int err_count = 0;
    int send_idle_pct = 7;
    int recv_idle_pct = 69;
    bit hold_go = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;
    int quiet_cycles = 0;

    one_bit_line_and_quad_rasterizer_top dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        err_count++;
    endtask

    // ---------------- predictor ----------------
    function automatic longint floor_quot(input longint n, input longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q--;
        return q;
    endfunction

    function automatic longint to_px(input longint v);
        return floor_quot(v + 128, 256);
    endfunction

    function automatic longint used_w();
        return (view_w > MAX_WIDTH) ? MAX_WIDTH : view_w;
    endfunction

    function automatic longint used_h();
        return (view_h > MAX_HEIGHT) ? MAX_HEIGHT : view_h;
    endfunction

    task automatic put_pixel(input longint x, input longint y, input logic pen);
        longint w, h, idx;
        logic [7:0] bitmask;
        w = used_w();
        h = used_h();
        if (x < 0 || y < 0 || x >= w || y >= h)
            return;
        idx = y * ((w + 7) / 8) + (x >>> 3);
        if (idx < 0 || idx >= STORE_DEPTH)
            return;
        bitmask = 8'h80 >> (x & 7);
        if (pen)
            frame[idx] = frame[idx] | bitmask;
        else
            frame[idx] = frame[idx] & ~bitmask;
    endtask

    task automatic trace_line(input cmd_t c);
        longint x0, y0, x1, y1, dx, dy, sx, sy, err, guard, e2;
        x0 = to_px(longint'(c.vx[0]));
        y0 = to_px(longint'(c.vy[0]));
        x1 = to_px(longint'(c.vx[1]));
        y1 = to_px(longint'(c.vy[1]));
        dx = (x1 > x0) ? x1 - x0 : x0 - x1;
        dy = (y1 > y0) ? y1 - y0 : y0 - y1;
        sx = (x0 < x1) ? 1 : -1;
        sy = (y0 < y1) ? 1 : -1;
        err = dx - dy;
        guard = dx + dy + 4;
        if (guard > GUARD_MAX)
            guard = GUARD_MAX;
        forever
        begin
            put_pixel(x0, y0, c.ink);
            if ((x0 == x1 && y0 == y1) || guard <= 0)
                break;
            guard--;
            e2 = 2 * err;
            if (e2 > -dy)
            begin
                err -= dy;
                x0 += sx;
            end
            if (e2 < dx)
            begin
                err += dx;
                y0 += sy;
            end
        end
    endtask

    task automatic fill_quad_spans(input cmd_t c);
        longint vx [4];
        longint vy [4];
        longint w, h, ymin, ymax, ylast, yc, lo, hi, xa, xb, num, den, q;
        int hits, j;
        w = used_w();
        h = used_h();
        for (int i = 0; i < 4; i++)
        begin
            vx[i] = longint'(c.vx[i]);
            vy[i] = longint'(c.vy[i]);
        end
        ymin = vy[0];
        ymax = vy[0];
        for (int i = 1; i < 4; i++)
        begin
            if (vy[i] < ymin) ymin = vy[i];
            if (vy[i] > ymax) ymax = vy[i];
        end
        if (ymin < 0) ymin = 0;
        if (ymax > (h - 1) * 256) ymax = (h - 1) * 256;
        ylast = to_px(ymax);
        for (longint y = to_px(ymin); y <= ylast; y++)
        begin
            yc = y * 256;
            lo = 0;
            hi = 0;
            hits = 0;
            for (int i = 0; i < 4; i++)
            begin
                j = (i + 1) & 3;
                if (vy[i] == vy[j])
                    continue;
                if (!((yc >= vy[i] && yc < vy[j]) || (yc >= vy[j] && yc < vy[i])))
                    continue;
                num = (yc - vy[i]) * (vx[j] - vx[i]);
                den = vy[j] - vy[i];
                if (den < 0)
                begin
                    den = -den;
                    num = -num;
                end
                q = vx[i] + floor_quot(2 * num + den, 2 * den);
                if (hits == 0 || q < lo) lo = q;
                if (hits == 0 || q > hi) hi = q;
                hits++;
            end
            if (hits < 2)
                continue;
            xa = to_px(lo);
            xb = to_px(hi);
            if (xa < 0) xa = 0;
            if (xb > w - 1) xb = w - 1;
            for (longint x = xa; x <= xb; x++)
                put_pixel(x, y, c.ink);
        end
    endtask

    task automatic predict_byte(input cmd_t c, output logic [7:0] rd);
        longint n;
        rd = 8'h00;
        case (c.mode)
            MODE_CLEAR:
            begin
                n = used_h() * ((used_w() + 7) / 8);
                if (n > STORE_DEPTH) n = STORE_DEPTH;
                for (longint i = 0; i < n; i++)
                    frame[i] = 8'h00;
            end
            MODE_LINE: trace_line(c);
            MODE_FILL: fill_quad_spans(c);
            default:
                if (c.ridx < STORE_DEPTH)
                    rd = frame[c.ridx];
        endcase
    endtask

    // ---------------- driver ----------------
    always @(posedge clk or negedge rst_n)
    begin
        logic [7:0] rd;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_byte(cur_cmd, rd);
                expected_bytes.push_back(rd);
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    cur_cmd = pending_cmds.pop_front();
                    mode <= cur_cmd.mode;
                    vertex0_x <= cur_cmd.vx[0];
                    vertex0_y <= cur_cmd.vy[0];
                    vertex1_x <= cur_cmd.vx[1];
                    vertex1_y <= cur_cmd.vy[1];
                    vertex2_x <= cur_cmd.vx[2];
                    vertex2_y <= cur_cmd.vy[2];
                    vertex3_x <= cur_cmd.vx[3];
                    vertex3_y <= cur_cmd.vy[3];
                    ink <= cur_cmd.ink;
                    read_index <= cur_cmd.ridx;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- receiver stall, with one long hold-off ----------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (hold_go && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_left <= 3000;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // ---------------- monitor ----------------
    always @(posedge clk)
    begin
        logic [7:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_bytes.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word read_data=%02h", read_data));
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (read_data !== want)
                    report_mismatch($sformatf("read_data got %02h want %02h", read_data, want));
            end
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // ---------------- stimulus ----------------
    task automatic add_cmd(input mode_t m, input int x0, input int y0, input int x1,
                           input int y1, input int x2, input int y2, input int x3,
                           input int y3, input logic pen, input int ridx);
        cmd_t c;
        c.mode = m;
        c.vx[0] = 24'(x0); c.vy[0] = 24'(y0);
        c.vx[1] = 24'(x1); c.vy[1] = 24'(y1);
        c.vx[2] = 24'(x2); c.vy[2] = 24'(y2);
        c.vx[3] = 24'(x3); c.vy[3] = 24'(y3);
        c.ink = pen;
        c.ridx = 14'(ridx);
        pending_cmds.push_back(c);
    endtask

    // The check runs after the edge has settled, so a word just handed to
    // the driver is seen as in flight.
    task automatic wait_idle();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (pending_cmds.size() != 0 || in_valid || expected_bytes.size() != 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 9'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_VIEW_WIDTH)
            view_w = value;
        else
            view_h = value;
    endtask

    task automatic set_view(input int w, input int h);
        wait_idle();
        write_reg(CFG_VIEW_WIDTH, w);
        @(posedge clk);
        write_reg(CFG_VIEW_HEIGHT, h);
        @(posedge clk);
    endtask

    // A pixel position with a random sub-pixel offset of up to half a pixel.
    function automatic int q8_near(input int px);
        return px * 256 + int'($urandom_range(0, 255)) - 128;
    endfunction

    task automatic gen_random(input int count, input int span_max, input bit wild_fill);
        cmd_t c;
        int w, h, stride, sel, cx, cy, r;
        w = (view_w > MAX_WIDTH) ? MAX_WIDTH : view_w;
        h = (view_h > MAX_HEIGHT) ? MAX_HEIGHT : view_h;
        stride = (w + 7) / 8;
        for (int n = 0; n < count; n++)
        begin
            sel = $urandom_range(0, 99);
            c.ink = $urandom_range(0, 1);
            c.ridx = 14'($urandom_range(0, 16383));
            for (int i = 0; i < 4; i++)
            begin
                c.vx[i] = 24'($urandom);
                c.vy[i] = 24'($urandom);
            end
            cx = $urandom_range(0, w + 3) - 2;
            cy = $urandom_range(0, h + 3) - 2;
            if (sel < 40)
            begin
                c.mode = MODE_READ;
                if ($urandom_range(0, 9) != 0)
                    c.ridx = 14'($urandom_range(0, h * stride + 1));
            end
            else if (sel < 65)
            begin
                c.mode = MODE_LINE;
                c.vx[0] = 24'(q8_near(cx));
                c.vy[0] = 24'(q8_near(cy));
                c.vx[1] = 24'(q8_near(cx + $urandom_range(0, 2 * span_max) - span_max));
                c.vy[1] = 24'(q8_near(cy + $urandom_range(0, 2 * span_max) - span_max));
            end
            else if (sel < 87)
            begin
                c.mode = MODE_FILL;
                r = $urandom_range(1, span_max);
                if ($urandom_range(0, 1))
                begin
                    // Jittered diamond, wound in order: convex.
                    c.vx[0] = 24'(q8_near(cx)); c.vy[0] = 24'(q8_near(cy - r));
                    c.vx[1] = 24'(q8_near(cx + r)); c.vy[1] = 24'(q8_near(cy));
                    c.vx[2] = 24'(q8_near(cx)); c.vy[2] = 24'(q8_near(cy + r));
                    c.vx[3] = 24'(q8_near(cx - r)); c.vy[3] = 24'(q8_near(cy));
                end
                else
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        c.vx[i] = 24'(q8_near(cx + $urandom_range(0, 2 * r) - r));
                        c.vy[i] = 24'(q8_near(cy + $urandom_range(0, 2 * r) - r));
                    end
                end
            end
            else if (sel < 92)
            begin
                c.mode = MODE_CLEAR;
            end
            else
            begin
                // Full-range coordinates; wide fills only where the view is cheap.
                c.mode = (wild_fill && $urandom_range(0, 1)) ? MODE_FILL : MODE_LINE;
            end
            pending_cmds.push_back(c);
        end
    endtask

    initial
    begin
        for (int i = 0; i < STORE_DEPTH; i++)
            frame[i] = 8'h00;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset view of 400 by 240.
        add_cmd(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_cmd(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 11999);
        add_cmd(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 12000);
        add_cmd(MODE_LINE, 0, 0, 399 * 256, 239 * 256, 0, 0, 0, 0, 1, 0);
        add_cmd(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_cmd(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 11999);
        add_cmd(MODE_LINE, 127, 128, 128 + 3 * 256, 127, 0, 0, 0, 0, 1, 0);
        add_cmd(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 50);
        // Long line: the step cap ends it beyond the view, after row two is drawn to its end.
        add_cmd(MODE_LINE, 0, 512, 8388607, 512, 0, 0, 0, 0, 1, 0);
        add_cmd(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 149);
        add_cmd(MODE_LINE, -8388608, -8388608, 8388607, 8388607, 0, 0, 0, 0, 1, 0);
        add_cmd(MODE_LINE, 0, 0, 399 * 256, 239 * 256, 0, 0, 0, 0, 0, 0);
        add_cmd(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_cmd(MODE_FILL, 2560, 2560, 5120, 3072, 4608, 5120, 2048, 4608, 1, 0);
        // Crossed quad: each row still fills from leftmost to rightmost crossing.
        add_cmd(MODE_FILL, 7680, 2560, 10240, 5120, 10240, 2560, 7680, 5120, 1, 0);
        add_cmd(MODE_FILL, 0, 1280, 9000, 1280, 5000, 1280, 700, 1280, 1, 0);
        add_cmd(MODE_FILL, 2000, 6000, 9000, 9000, 9000, 9000, 100, 8000, 1, 0);
        add_cmd(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 15 * 50 + 1);
        add_cmd(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 15 * 50 + 4);
        add_cmd(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_cmd(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 15 * 50 + 1);
        add_cmd(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16383);

        // Oversized view saturates to the maximum.
        set_view(511, 255);
        add_cmd(MODE_LINE, 0, 0, 400 * 256, 240 * 256, 0, 0, 0, 0, 1, 0);
        add_cmd(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 11999);
        add_cmd(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_cmd(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 11999);

        // Zero view: after a line is drawn at the full view, nothing is drawn or cleared.
        set_view(400, 240);
        add_cmd(MODE_LINE, 0, 256, 50 * 256, 256, 0, 0, 0, 0, 1, 0);
        set_view(0, 0);
        add_cmd(MODE_LINE, 0, 0, 30 * 256, 30 * 256, 0, 0, 0, 0, 1, 0);
        add_cmd(MODE_FILL, 0, 0, 2560, 0, 2560, 2560, 0, 2560, 1, 0);
        add_cmd(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_cmd(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 50);

        // Stride change without a clear reinterprets the same bytes.
        set_view(200, 240);
        add_cmd(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 50);
        add_cmd(MODE_LINE, 0, 3 * 256, 199 * 256, 3 * 256, 0, 0, 0, 0, 1, 0);
        set_view(400, 240);
        add_cmd(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 75);
        add_cmd(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 76);

        // Extreme vertices covering a small view completely.
        set_view(40, 30);
        add_cmd(MODE_FILL, -8388608, -8388608, 8388607, -8388608, 8388607, 8388607,
                -8388608, 8388607, 1, 0);
        add_cmd(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_cmd(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 149);
        add_cmd(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 150);
        wait_idle();

        // Random part; the long receiver hold-off falls at the start.
        hold_go = 1'b1;
        gen_random(150, 12, 1'b1);
        set_view(13, 7);
        gen_random(100, 8, 1'b1);
        wait_idle();
        send_idle_pct = 69;
        recv_idle_pct = 7;
        set_view(1, 1);
        gen_random(40, 3, 1'b1);
        set_view(96, 64);
        gen_random(130, 10, 1'b0);
        wait_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_view(400, 240);
        gen_random(120, 8, 1'b0);
        set_view(57, 19);
        gen_random(60, 10, 1'b1);

        wait_idle();
        repeat (50) @(posedge clk);
        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
